// ===== rtl/sacr_pkg.sv =====
// Shared types, codes and constants for the SPI converter reader.
package sacr_pkg;

  localparam int LINE_W          = 4;
  localparam int DEV_W           = 2;
  localparam int TICK_W          = 10;
  localparam int BIT_W           = 4;
  localparam int SHIFT_W         = 13;
  localparam int SAMPLE_W        = 12;
  localparam int DEF_NUM_DEVICES = 4;

  localparam logic [BIT_W-1:0] CMD_BITS     = 4'd4;
  localparam logic [BIT_W-1:0] DATA_BITS    = 4'd13;
  localparam logic [BIT_W-1:0] CMD_MODE_POS = 4'd1;
  localparam logic [BIT_W-1:0] CMD_CHAN_POS = 4'd2;

  localparam logic [TICK_W-1:0] RST_HALF_PERIOD = 10'd100;
  localparam logic [TICK_W-1:0] RST_SETUP       = 10'd20;
  localparam logic [TICK_W-1:0] RST_TAIL        = 10'd100;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_HALF_PERIOD = 2'd0,
    CFG_SETUP       = 2'd1,
    CFG_TAIL        = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [TICK_W-1:0] half_period_ticks;
    logic [TICK_W-1:0] setup_ticks;
    logic [TICK_W-1:0] tail_ticks;
  } cfg_regs_t;

  typedef struct packed {
    logic              start_req;
    logic [DEV_W-1:0]  device_index;
    logic              channel;
    logic              single_ended;
    logic [LINE_W-1:0] data_lines;
  } in_item_t;

  typedef struct packed {
    logic [LINE_W-1:0]   select_lines;
    logic [LINE_W-1:0]   clock_lines;
    logic [LINE_W-1:0]   command_lines;
    logic                busy_res;
    logic                done_res;
    logic [SAMPLE_W-1:0] sample;
  } out_res_t;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_SETUP     = 7'b0000010,
    PH_CMD_HIGH  = 7'b0000100,
    PH_CMD_LOW   = 7'b0001000,
    PH_DATA_HIGH = 7'b0010000,
    PH_DATA_LOW  = 7'b0100000,
    PH_TAIL      = 7'b1000000
  } phase_t;

endpackage

// ===== rtl/sacr_cfg.sv =====
// Timing configuration registers of the SPI converter reader.
module sacr_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [1:0]                     wr_index,
  input  logic [sacr_pkg::TICK_W-1:0]    wr_data,
  output sacr_pkg::cfg_regs_t            regs
);
  import sacr_pkg::*;

  cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.half_period_ticks <= RST_HALF_PERIOD;
      regs_r.setup_ticks       <= RST_SETUP;
      regs_r.tail_ticks        <= RST_TAIL;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_HALF_PERIOD: regs_r.half_period_ticks <= wr_data;
        CFG_SETUP:       regs_r.setup_ticks       <= wr_data;
        CFG_TAIL:        regs_r.tail_ticks        <= wr_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  assign regs = regs_r;

endmodule

// ===== rtl/sacr_seq.sv =====
// Bus sequencer: phase, tick and bit counters, shift register, pin levels.
module sacr_seq #(
  parameter int NUM_DEVICES = sacr_pkg::DEF_NUM_DEVICES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  sacr_pkg::in_item_t   item,
  input  sacr_pkg::cfg_regs_t  regs,
  output sacr_pkg::out_res_t   res_nxt
);
  import sacr_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [BIT_W-1:0]    bit_r, bit_nxt;
  logic [SHIFT_W-1:0]  shift_r, shift_nxt;
  logic [DEV_W-1:0]    dev_r, dev_nxt;
  logic                chan_r, chan_nxt;
  logic                mode_r, mode_nxt;
  logic                clk_lvl_r, clk_lvl_nxt;
  logic                cmd_lvl_r, cmd_lvl_nxt;
  logic [SAMPLE_W-1:0] hold_r, hold_nxt;
  logic                done;
  logic [TICK_W:0]     tick_inc;
  logic [TICK_W-1:0]   phase_len;
  logic [BIT_W-1:0]    bit_inc;
  logic [LINE_W-1:0]   dev_mask;

  assign tick_inc = {1'b0, tick_r} + {{TICK_W{1'b0}}, 1'b1};
  assign bit_inc  = bit_r + {{(BIT_W-1){1'b0}}, 1'b1};

  always_comb begin
    case (phase_r)
      PH_SETUP: phase_len = regs.setup_ticks;
      PH_TAIL:  phase_len = regs.tail_ticks;
      default:  phase_len = regs.half_period_ticks;
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    dev_nxt     = dev_r;
    chan_nxt    = chan_r;
    mode_nxt    = mode_r;
    clk_lvl_nxt = clk_lvl_r;
    cmd_lvl_nxt = cmd_lvl_r;
    hold_nxt    = hold_r;
    done        = 1'b0;
    if (phase_r == PH_IDLE) begin
      if (item.start_req && (int'(item.device_index) < NUM_DEVICES)) begin
        dev_nxt     = item.device_index;
        chan_nxt    = item.channel;
        mode_nxt    = item.single_ended;
        phase_nxt   = PH_SETUP;
        tick_nxt    = '0;
        bit_nxt     = '0;
        shift_nxt   = '0;
        clk_lvl_nxt = 1'b0;
        cmd_lvl_nxt = 1'b1;
      end
    end else if (tick_inc < {1'b0, phase_len}) begin
      tick_nxt = tick_inc[TICK_W-1:0];
    end else begin
      tick_nxt = '0;
      unique case (phase_r)
        PH_SETUP: begin
          phase_nxt   = PH_CMD_HIGH;
          clk_lvl_nxt = 1'b1;
          bit_nxt     = '0;
        end
        PH_CMD_HIGH: begin
          // command pin moves on the falling edge
          phase_nxt   = PH_CMD_LOW;
          clk_lvl_nxt = 1'b0;
          if (bit_inc == CMD_MODE_POS)      cmd_lvl_nxt = mode_r;
          else if (bit_inc == CMD_CHAN_POS) cmd_lvl_nxt = chan_r;
          else                              cmd_lvl_nxt = 1'b1;
        end
        PH_CMD_LOW: begin
          clk_lvl_nxt = 1'b1;
          if (bit_inc >= CMD_BITS) begin
            bit_nxt   = '0;
            phase_nxt = PH_DATA_HIGH;
          end else begin
            bit_nxt   = bit_inc;
            phase_nxt = PH_CMD_HIGH;
          end
        end
        PH_DATA_HIGH: begin
          phase_nxt   = PH_DATA_LOW;
          clk_lvl_nxt = 1'b0;
        end
        PH_DATA_LOW: begin
          shift_nxt = {shift_r[SHIFT_W-2:0], item.data_lines[dev_r]};
          bit_nxt   = bit_inc;
          if (bit_inc >= DATA_BITS) begin
            phase_nxt   = PH_TAIL;
            cmd_lvl_nxt = 1'b1;
          end else begin
            phase_nxt   = PH_DATA_HIGH;
            clk_lvl_nxt = 1'b1;
          end
        end
        PH_TAIL: begin
          // drop the thirteenth bit, keep twelve MSB-first
          phase_nxt   = PH_IDLE;
          hold_nxt    = shift_r[SHIFT_W-1:1];
          done        = 1'b1;
          clk_lvl_nxt = 1'b0;
          cmd_lvl_nxt = 1'b1;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  assign dev_mask = {{(LINE_W-1){1'b0}}, 1'b1} << dev_nxt;

  always_comb begin
    res_nxt.select_lines  = '1;
    res_nxt.clock_lines   = '0;
    res_nxt.command_lines = '1;
    if (phase_nxt != PH_IDLE) begin
      if (phase_nxt != PH_TAIL) res_nxt.select_lines  = ~dev_mask;
      if (clk_lvl_nxt)          res_nxt.clock_lines   = dev_mask;
      if (!cmd_lvl_nxt)         res_nxt.command_lines = ~dev_mask;
    end
    res_nxt.busy_res = (phase_nxt != PH_IDLE);
    res_nxt.done_res = done;
    res_nxt.sample   = hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= '0;
      bit_r     <= '0;
      shift_r   <= '0;
      dev_r     <= '0;
      chan_r    <= 1'b0;
      mode_r    <= 1'b0;
      clk_lvl_r <= 1'b0;
      cmd_lvl_r <= 1'b1;
      hold_r    <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      dev_r     <= dev_nxt;
      chan_r    <= chan_nxt;
      mode_r    <= mode_nxt;
      clk_lvl_r <= clk_lvl_nxt;
      cmd_lvl_r <= cmd_lvl_nxt;
      hold_r    <= hold_nxt;
    end
  end

  a_done_from_tail: assert property (@(posedge clk) disable iff (!rst_n)
    res_nxt.done_res |-> (phase_r == PH_TAIL) && (phase_nxt == PH_IDLE))
    else $error("done raised outside the tail phase");

  a_clock_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE || phase_r == PH_SETUP || phase_r == PH_TAIL) |-> !clk_lvl_r)
    else $error("serial clock high outside a bit phase");

  // the count rests at thirteen through the tail and until the next start
  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= DATA_BITS)
    else $error("bit counter out of range");

  a_hold_steady: assert property (@(posedge clk) disable iff (!rst_n)
    !(step && done) |=> $stable(hold_r))
    else $error("sample changed without a done");

endmodule

// ===== rtl/spi_adc_conversion_reader.sv =====
// Top level of the tick-driven SPI reader for 12-bit two-channel converters.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data): one request per timebase
//   tick, carrying the start request, device, channel, mode and the sampled
//   data-out pins of all devices. A request is taken on a rising edge with
//   in_valid high and in_stall low.
//   Result channel (out_valid / out_stall / out_data): exactly one result per
//   request, in order: the select, clock and command pin levels after that
//   tick, busy, a one-tick done pulse and the last sample.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): half
//   period, setup and tail tick counts; cfg_ready is always high. Write only
//   while no request is in flight.
//   A request passes an input register, then the sequencer logic into the
//   output register. Throughput is one request per cycle while the output
//   is not stalled, set by the sequencer state update.
//   A stalled output holds its result; the input register still takes one
//   more request, and in_stall rises only once both stages are full.
//   Reset (rst_n low, synchronous) empties both stages, idles the sequencer
//   (next result: select high, clock low, command high), loads 100/20/100 ticks.
module spi_adc_conversion_reader #(
  parameter int NUM_DEVICES = sacr_pkg::DEF_NUM_DEVICES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sacr_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sacr_pkg::out_res_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [sacr_pkg::TICK_W-1:0] cfg_data
);
  import sacr_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_res_t  out_data_r;
  out_res_t  res_nxt;
  cfg_regs_t regs;
  logic      in_take;
  logic      out_hold;
  logic      advance;

  // Output side blocked: a result waits and the receiver stalls.
  assign out_hold  = out_valid_r && out_stall;
  // The input-stage request moves into the sequencer and output register.
  assign advance   = s1_valid_r && !out_hold;
  assign in_stall  = s1_valid_r && out_hold;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || out_hold;

  sacr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .regs     (regs)
  );

  sacr_seq #(
    .NUM_DEVICES (NUM_DEVICES)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .item    (s1_item_r),
    .regs    (regs),
    .res_nxt (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced request left no result");

  a_full_means_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_hold) |=> s1_valid_r && out_valid_r)
    else $error("a stage emptied while the output was stalled");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && s1_valid_r && out_hold) |=> $stable(s1_item_r))
    else $error("input stage overwritten while full");

endmodule
